FILE: sv/svmie_pkg.sv
// ----------------------------------------------------------------------------
// svmie_pkg: scheduling VM execute, shared types and opcodes
// Transfer payloads, opcode codes and the register write request.
// ----------------------------------------------------------------------------
package svmie_pkg;

	localparam int REG_IDX_W = 5;
	localparam int DATA_W    = 64;
	localparam int OUT_PC_W  = 16;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_ADDI = 4'd1;
	localparam logic [3:0] OP_BEQ  = 4'd2;
	localparam logic [3:0] OP_BGE  = 4'd3;
	localparam logic [3:0] OP_BLT  = 4'd4;
	localparam logic [3:0] OP_BNE  = 4'd5;
	localparam logic [3:0] OP_DU   = 4'd6;
	localparam logic [3:0] OP_EXE  = 4'd7;
	localparam logic [3:0] OP_WLT  = 4'd8;
	localparam logic [3:0] OP_WU   = 4'd9;
	localparam logic [3:0] OP_JAL  = 4'd10;
	localparam logic [3:0] OP_JALR = 4'd11;
	localparam logic [3:0] OP_STP  = 4'd12;

	typedef struct packed {
		logic [3:0]           mode;
		logic [REG_IDX_W-1:0] reg_a;
		logic [REG_IDX_W-1:0] reg_b;
		logic [REG_IDX_W-1:0] reg_c;
		logic                 a_present;
		logic                 b_present;
		logic signed [DATA_W-1:0] imm_b;
		logic signed [DATA_W-1:0] imm_c;
		logic signed [DATA_W-1:0] now_time;
	} instr_t;

	typedef struct packed {
		logic [OUT_PC_W-1:0]      next_pc;
		logic                     waiting;
		logic                     halted;
		logic                     dispatch_valid;
		logic signed [DATA_W-1:0] dispatch_function;
		logic signed [DATA_W-1:0] dispatch_argument;
	} result_t;

	typedef struct packed {
		logic                 en;
		logic [REG_IDX_W-1:0] idx;
		logic [DATA_W-1:0]    data;
	} reg_wr_t;

endpackage

FILE: sv/schedule_vm_instruction_execute.sv
// ----------------------------------------------------------------------------
// schedule_vm_instruction_execute: scheduling VM instruction execute
// Register file read at transfer, then execute into the result register.
// Throughput one instruction per cycle unless result_ready stalls, set by
// the register file write-back with forwarding. Reset clears pc, halt flag,
// register valid bits and both stages; registers read as zero until written.
// ----------------------------------------------------------------------------
module schedule_vm_instruction_execute #(
	parameter int NUM_REGS = 32,
	parameter int PC_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                instr_valid,
	output logic                instr_ready,
	input  svmie_pkg::instr_t   instr,
	output logic                result_valid,
	input  logic                result_ready,
	output svmie_pkg::result_t  result
);

	logic                         valid_s1;
	svmie_pkg::instr_t            item_s1;
	logic                         adv_s1;
	logic                         accept;
	logic [PC_WIDTH-1:0]          pc_q;
	logic                         stopped_q;
	logic                         result_valid_q;
	svmie_pkg::result_t           result_q;
	logic [svmie_pkg::DATA_W-1:0] op1, op2;
	logic [PC_WIDTH-1:0]          npc;
	logic                         stopped_nxt;
	svmie_pkg::reg_wr_t           wr_req, wr_gated;
	svmie_pkg::result_t           res;
	logic [svmie_pkg::REG_IDX_W-1:0] rd_idx1;

	assign adv_s1      = valid_s1 && (!result_valid_q || result_ready);
	assign instr_ready = !valid_s1 || adv_s1;
	assign accept      = instr_valid && instr_ready;
	assign rd_idx1     = (instr.mode == svmie_pkg::OP_ADD) ? instr.reg_c : instr.reg_a;

	always_comb begin
		wr_gated    = wr_req;
		wr_gated.en = wr_req.en && adv_s1;
	end

	svmie_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx1  (rd_idx1),
		.rd_idx2  (instr.reg_b),
		.wr       (wr_gated),
		.rd_data1 (op1),
		.rd_data2 (op2)
	);

	svmie_exec #(
		.NUM_REGS(NUM_REGS),
		.PC_WIDTH(PC_WIDTH)
	) u_exec (
		.item        (item_s1),
		.op1         (op1),
		.op2         (op2),
		.pc          (pc_q),
		.stopped     (stopped_q),
		.npc         (npc),
		.stopped_nxt (stopped_nxt),
		.wr          (wr_req),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			pc_q           <= '0;
			stopped_q      <= 1'b0;
		end else begin
			if (instr_ready) begin
				valid_s1 <= instr_valid;
			end
			if (adv_s1) begin
				result_valid_q <= 1'b1;
				pc_q           <= npc;
				stopped_q      <= stopped_nxt;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= instr;
		end
		if (adv_s1) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: sv/svmie_ram.sv
// ----------------------------------------------------------------------------
// svmie_ram: generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module svmie_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

FILE: sv/svmie_regfile.sv
// ----------------------------------------------------------------------------
// svmie_regfile: register file
// RAM with per-entry valid bits, zero for unwritten or absent registers,
// and forwarding of the latest write to reads issued alongside it.
// ----------------------------------------------------------------------------
module svmie_regfile #(
	parameter int NUM_REGS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [svmie_pkg::REG_IDX_W-1:0] rd_idx1,
	input  logic [svmie_pkg::REG_IDX_W-1:0] rd_idx2,
	input  svmie_pkg::reg_wr_t              wr,
	output logic [svmie_pkg::DATA_W-1:0]    rd_data1,
	output logic [svmie_pkg::DATA_W-1:0]    rd_data2
);

	localparam int RF_DEPTH = (NUM_REGS < 32) ? NUM_REGS : 32;
	localparam int RF_AW    = $clog2(RF_DEPTH);

	logic [RF_DEPTH-1:0]                valid_q;
	logic                               ok1_q, ok2_q;
	logic [svmie_pkg::REG_IDX_W-1:0]    idx1_q, idx2_q;
	logic                               byp_en_q;
	logic [svmie_pkg::REG_IDX_W-1:0]    byp_idx_q;
	logic [svmie_pkg::DATA_W-1:0]       byp_data_q;
	logic [svmie_pkg::DATA_W-1:0]       ram1, ram2;
	logic                               rng1, rng2;

	assign rng1 = {1'b0, rd_idx1} < (svmie_pkg::REG_IDX_W + 1)'(RF_DEPTH);
	assign rng2 = {1'b0, rd_idx2} < (svmie_pkg::REG_IDX_W + 1)'(RF_DEPTH);

	svmie_ram #(
		.WIDTH(svmie_pkg::DATA_W),
		.DEPTH(RF_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (wr.en),
		.waddr  (wr.idx[RF_AW-1:0]),
		.wdata  (wr.data),
		.re     (rd_en),
		.raddr0 (rd_idx1[RF_AW-1:0]),
		.raddr1 (rd_idx2[RF_AW-1:0]),
		.rdata0 (ram1),
		.rdata1 (ram2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			byp_en_q <= 1'b0;
		end else if (wr.en) begin
			valid_q[wr.idx[RF_AW-1:0]] <= 1'b1;
			byp_en_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			byp_idx_q  <= wr.idx;
			byp_data_q <= wr.data;
		end
		if (rd_en) begin
			ok1_q  <= rng1 && valid_q[rd_idx1[RF_AW-1:0]];
			ok2_q  <= rng2 && valid_q[rd_idx2[RF_AW-1:0]];
			idx1_q <= rd_idx1;
			idx2_q <= rd_idx2;
		end
	end

	// forward the latest write, else zero for unwritten entries
	always_comb begin
		if (byp_en_q && byp_idx_q == idx1_q) begin
			rd_data1 = byp_data_q;
		end else begin
			rd_data1 = ok1_q ? ram1 : '0;
		end
		if (byp_en_q && byp_idx_q == idx2_q) begin
			rd_data2 = byp_data_q;
		end else begin
			rd_data2 = ok2_q ? ram2 : '0;
		end
	end

endmodule

FILE: sv/svmie_exec.sv
// ----------------------------------------------------------------------------
// svmie_exec: execute unit
// Operation decode, add, compare, next pc, register write request and result.
// ----------------------------------------------------------------------------
module svmie_exec #(
	parameter int NUM_REGS = 32,
	parameter int PC_WIDTH = 16
) (
	input  svmie_pkg::instr_t            item,
	input  logic [svmie_pkg::DATA_W-1:0] op1,
	input  logic [svmie_pkg::DATA_W-1:0] op2,
	input  logic [PC_WIDTH-1:0]          pc,
	input  logic                         stopped,
	output logic [PC_WIDTH-1:0]          npc,
	output logic                         stopped_nxt,
	output svmie_pkg::reg_wr_t           wr,
	output svmie_pkg::result_t           res
);

	localparam int RF_DEPTH = (NUM_REGS < 32) ? NUM_REGS : 32;

	logic [PC_WIDTH-1:0]                pc_inc;
	logic signed [svmie_pkg::DATA_W-1:0] va, vb, wake;
	logic [svmie_pkg::DATA_W-1:0]       link, base, jsum;
	logic                               both, rng_a;

	always_comb begin
		pc_inc = pc + PC_WIDTH'(1);
		va     = op1;
		vb     = op2;
		wake   = va + item.imm_b;
		link   = svmie_pkg::DATA_W'(pc_inc);
		both   = item.a_present && item.b_present;
		rng_a  = {1'b0, item.reg_a} < (svmie_pkg::REG_IDX_W + 1)'(RF_DEPTH);
		base   = op2;
		jsum   = '0;

		npc         = pc_inc;
		stopped_nxt = stopped;
		wr          = '0;
		wr.idx      = item.reg_a;
		res         = '0;

		if (stopped) begin
			npc = pc;
		end else begin
			case (item.mode)
				svmie_pkg::OP_ADD: begin
					wr.en   = rng_a;
					wr.data = op2 + op1;
				end
				svmie_pkg::OP_ADDI: begin
					wr.en   = rng_a;
					wr.data = op2 + item.imm_c;
				end
				svmie_pkg::OP_BEQ: begin
					if (both && va == vb) npc = item.imm_c[PC_WIDTH-1:0];
				end
				svmie_pkg::OP_BGE: begin
					if (both && !(va < vb)) npc = item.imm_c[PC_WIDTH-1:0];
				end
				svmie_pkg::OP_BLT: begin
					if (both && va < vb) npc = item.imm_c[PC_WIDTH-1:0];
				end
				svmie_pkg::OP_BNE: begin
					if (both && va != vb) npc = item.imm_c[PC_WIDTH-1:0];
				end
				svmie_pkg::OP_DU: begin
					if (item.now_time < wake) begin
						res.waiting = 1'b1;
						npc         = pc;
					end
				end
				svmie_pkg::OP_EXE: begin
					res.dispatch_valid    = 1'b1;
					res.dispatch_function = item.imm_b;
					res.dispatch_argument = item.imm_c;
				end
				svmie_pkg::OP_WLT: begin
					if (!(va < item.imm_b)) begin
						res.waiting = 1'b1;
						npc         = pc;
					end
				end
				svmie_pkg::OP_WU: begin
					if (va < item.imm_b) begin
						res.waiting = 1'b1;
						npc         = pc;
					end
				end
				svmie_pkg::OP_JAL: begin
					wr.en   = rng_a && item.reg_a != '0;
					wr.data = link;
					jsum    = item.imm_b + item.imm_c;
					npc     = jsum[PC_WIDTH-1:0];
				end
				svmie_pkg::OP_JALR: begin
					wr.en   = rng_a && item.reg_a != '0;
					wr.data = link;
					// base sees the link write
					if (wr.en && item.reg_a == item.reg_b) base = link;
					jsum    = base + item.imm_c;
					npc     = jsum[PC_WIDTH-1:0];
				end
				svmie_pkg::OP_STP: begin
					stopped_nxt = 1'b1;
					npc         = pc;
				end
				default: begin
				end
			endcase
		end

		res.next_pc = svmie_pkg::OUT_PC_W'(32'(npc));
		res.halted  = stopped_nxt;
	end

endmodule

FILE: bench/schedule_vm_instruction_execute_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schedule_vm_instruction_execute_test: execute stage self-checking bench
// Drives decoded instructions through the valid/ready input channel and
// checks every result transfer against a cycle-free model of the register
// file, pc and halt flag, or a typed row's own expectation. A directed
// table opens and closes the run (the closing rows halt the machine), with
// random instructions between. Both channels idle in random bursts except at the end.
// ----------------------------------------------------------------------------
module schedule_vm_instruction_execute_test;

	localparam logic [3:0] OP_SPARE_LO = 4'd13;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;
	localparam logic signed [63:0] MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MINV = 64'sh8000_0000_0000_0000;
	localparam int N_RANDOM     = 1520;
	localparam int CALM_ITEMS   = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam longint LIMIT_NS = 5_000_000;

	typedef struct {
		svmie_pkg::instr_t  ins;
		bit                 typed;
		svmie_pkg::result_t want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               instr_valid;
	logic               instr_ready;
	svmie_pkg::instr_t  instr;
	logic               result_valid;
	logic               result_ready;
	svmie_pkg::result_t result;

	// per-transfer tag: hand-written expectation travelling with the instruction
	bit                 tag_typed;
	svmie_pkg::result_t tag_want;

	logic signed [63:0] gpr [32];
	logic [15:0]        pc_now;
	bit                 machine_stopped;

	svmie_pkg::result_t outstanding [$];
	svmie_pkg::result_t oldest;
	svmie_pkg::result_t computed;
	int                 errors;
	bit                 calm;

	schedule_vm_instruction_execute u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.instr       (instr),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic svmie_pkg::result_t execute(input svmie_pkg::instr_t ins);
		svmie_pkg::result_t r;
		logic signed [63:0] va;
		logic signed [63:0] vb;
		logic signed [63:0] wake;
		logic [15:0]        pc;
		logic [15:0]        npc;
		bit                 both;
		r = '0;
		pc = pc_now;
		npc = pc + 16'd1;
		if (machine_stopped) begin
			npc = pc;
		end else begin
			va = gpr[ins.reg_a];
			vb = gpr[ins.reg_b];
			both = ins.a_present && ins.b_present;
			case (ins.mode)
				svmie_pkg::OP_ADD:  gpr[ins.reg_a] = vb + gpr[ins.reg_c];
				svmie_pkg::OP_ADDI: gpr[ins.reg_a] = vb + $signed(ins.imm_c);
				svmie_pkg::OP_BEQ:  if (both && va == vb) npc = ins.imm_c[15:0];
				svmie_pkg::OP_BGE:  if (both && !(va < vb)) npc = ins.imm_c[15:0];
				svmie_pkg::OP_BLT:  if (both && va < vb) npc = ins.imm_c[15:0];
				svmie_pkg::OP_BNE:  if (both && va != vb) npc = ins.imm_c[15:0];
				svmie_pkg::OP_DU: begin
					wake = va + $signed(ins.imm_b);
					if ($signed(ins.now_time) < wake) begin
						r.waiting = 1'b1;
						npc = pc;
					end
				end
				svmie_pkg::OP_EXE: begin
					r.dispatch_valid = 1'b1;
					r.dispatch_function = ins.imm_b;
					r.dispatch_argument = ins.imm_c;
				end
				svmie_pkg::OP_WLT: begin
					if (!(va < $signed(ins.imm_b))) begin
						r.waiting = 1'b1;
						npc = pc;
					end
				end
				svmie_pkg::OP_WU: begin
					if (va < $signed(ins.imm_b)) begin
						r.waiting = 1'b1;
						npc = pc;
					end
				end
				svmie_pkg::OP_JAL: begin
					if (ins.reg_a != 0) gpr[ins.reg_a] = {48'd0, pc + 16'd1};
					npc = 16'(ins.imm_b + ins.imm_c);
				end
				svmie_pkg::OP_JALR: begin
					// base is read after the link write
					if (ins.reg_a != 0) gpr[ins.reg_a] = {48'd0, pc + 16'd1};
					npc = 16'(gpr[ins.reg_b] + ins.imm_c);
				end
				svmie_pkg::OP_STP: begin
					machine_stopped = 1'b1;
					npc = pc;
				end
				default: ;
			endcase
		end
		pc_now = npc;
		r.next_pc = npc;
		r.halted = machine_stopped;
		return r;
	endfunction

	function automatic svmie_pkg::instr_t op(input logic [3:0] mode, input int a, input int b,
			input int c, input int ap, input int bp, input logic signed [63:0] imb,
			input logic signed [63:0] imc, input logic signed [63:0] now);
		svmie_pkg::instr_t ins;
		ins.mode = mode;
		ins.reg_a = 5'(a);
		ins.reg_b = 5'(b);
		ins.reg_c = 5'(c);
		ins.a_present = 1'(ap);
		ins.b_present = 1'(bp);
		ins.imm_b = imb;
		ins.imm_c = imc;
		ins.now_time = now;
		return ins;
	endfunction

	function automatic svmie_pkg::result_t outcome(input logic [15:0] pc, input bit disp,
			input logic signed [63:0] fn, input logic signed [63:0] arg);
		svmie_pkg::result_t r;
		r = '0;
		r.next_pc = pc;
		r.dispatch_valid = disp;
		r.dispatch_function = fn;
		r.dispatch_argument = arg;
		return r;
	endfunction

	function automatic logic signed [63:0] pick_value();
		logic signed [63:0] v;
		int                 s;
		case ($urandom_range(0, 9))
			0: v = MAXV;
			1: v = MINV;
			2: v = '0;
			3: v = -64'sd1;
			4, 5, 6, 7: begin
				s = int'($urandom_range(0, 8)) - 4;
				v = 64'(s);
			end
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [4:0] pick_index();
		if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, 7));
	endfunction

	function automatic svmie_pkg::instr_t random_instr();
		svmie_pkg::instr_t ins;
		ins.mode = 4'($urandom_range(svmie_pkg::OP_ADD, OP_SPARE_HI));
		// keep the machine running until the closing rows
		if (ins.mode == svmie_pkg::OP_STP) ins.mode = svmie_pkg::OP_ADDI;
		ins.reg_a = pick_index();
		ins.reg_b = pick_index();
		ins.reg_c = pick_index();
		ins.a_present = ($urandom_range(0, 4) != 0);
		ins.b_present = ($urandom_range(0, 4) != 0);
		ins.imm_b = pick_value();
		ins.imm_c = pick_value();
		ins.now_time = pick_value();
		return ins;
	endfunction

	task automatic mismatch(input string field, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: %s expected %h, got %h", $time, field, want, got);
		errors++;
	endtask

	task automatic send(input svmie_pkg::instr_t ins, input bit typed,
			input svmie_pkg::result_t want);
		if (!calm && $urandom_range(0, 3) == 0) begin
			instr_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		instr_valid <= 1'b1;
		instr <= ins;
		tag_typed <= typed;
		tag_want <= want;
		do @(posedge clk); while (!instr_ready);
	endtask

	always @(posedge clk) begin
		if (instr_valid && instr_ready) begin
			computed = execute(instr);
			outstanding.push_back(tag_typed ? tag_want : computed);
		end
		if (result_valid && result_ready) begin
			if (outstanding.size() == 0) begin
				$display("%0t: result with none outstanding, got %h", $time, result);
				errors++;
			end else begin
				oldest = outstanding.pop_front();
				if (result.next_pc !== oldest.next_pc)
					mismatch("next_pc", 64'(oldest.next_pc), 64'(result.next_pc));
				if (result.waiting !== oldest.waiting)
					mismatch("waiting", 64'(oldest.waiting), 64'(result.waiting));
				if (result.halted !== oldest.halted)
					mismatch("halted", 64'(oldest.halted), 64'(result.halted));
				if (result.dispatch_valid !== oldest.dispatch_valid)
					mismatch("dispatch_valid", 64'(oldest.dispatch_valid),
						64'(result.dispatch_valid));
				if (result.dispatch_function !== oldest.dispatch_function)
					mismatch("dispatch_function", oldest.dispatch_function,
						result.dispatch_function);
				if (result.dispatch_argument !== oldest.dispatch_argument)
					mismatch("dispatch_argument", oldest.dispatch_argument,
						result.dispatch_argument);
			end
		end
	end

	initial begin
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (calm || $urandom_range(0, 4) != 0) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		row_t lead [$];
		row_t tail [$];
		arst_n = 1'b0;
		instr_valid = 1'b0;
		instr = '0;
		tag_typed = 1'b0;
		tag_want = '0;
		errors = 0;
		calm = 1'b0;
		pc_now = '0;
		machine_stopped = 1'b0;
		foreach (gpr[i]) gpr[i] = '0;

		lead.push_back('{op(svmie_pkg::OP_EXE, 0, 0, 0, 0, 0, MAXV, MINV, 0), 1'b1,
			outcome(16'd1, 1'b1, MAXV, MINV)});
		lead.push_back('{op(svmie_pkg::OP_ADDI, 1, 0, 0, 0, 0, 0, MAXV, 0), 1'b1,
			outcome(16'd2, 1'b0, 0, 0)});
		lead.push_back('{op(svmie_pkg::OP_ADDI, 2, 0, 0, 0, 0, 0, MINV, 0), 1'b1,
			outcome(16'd3, 1'b0, 0, 0)});
		lead.push_back('{op(svmie_pkg::OP_ADD, 3, 1, 2, 0, 0, 0, 0, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_ADD, 0, 1, 1, 0, 0, 0, 0, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_ADDI, 31, 31, 0, 0, 0, 0, -64'sd1, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_BLT, 2, 1, 0, 1, 1, 0, 64'shFFFF_0000_0000_0014, 0),
			1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_BGE, 1, 2, 0, 1, 1, 0, 30, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_BEQ, 3, 3, 0, 0, 1, 0, 40, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_BNE, 1, 2, 0, 1, 0, 0, 50, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_BEQ, 1, 1, 0, 1, 1, 0, 100, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_BNE, 1, 2, 0, 1, 1, 0, 200, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_BGE, 2, 1, 0, 1, 1, 0, 300, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_BLT, 1, 2, 0, 1, 1, 0, 400, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_WU, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_WU, 1, 0, 0, 0, 0, MAXV, 0, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_WLT, 2, 0, 0, 0, 0, MINV, 0, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_WLT, 2, 0, 0, 0, 0, MAXV, 0, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_DU, 2, 0, 0, 0, 0, MINV, 0, -64'sd1), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_DU, 1, 0, 0, 0, 0, 1, 0, MINV), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_JAL, 0, 0, 0, 0, 0, MAXV, 1, 0), 1'b1,
			outcome(16'd0, 1'b0, 0, 0)});
		lead.push_back('{op(svmie_pkg::OP_JAL, 5, 0, 0, 0, 0, 64'sh1000, -64'sd1, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_JALR, 6, 6, 0, 0, 0, 0, 64'sh10, 0), 1'b0, '0});
		lead.push_back('{op(svmie_pkg::OP_JALR, 0, 5, 0, 0, 0, 0, -64'sd2, 0), 1'b0, '0});
		lead.push_back('{op(OP_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		lead.push_back('{op(OP_SPARE_HI, 31, 31, 31, 1, 1, -64'sd1, -64'sd1, -64'sd1), 1'b0, '0});

		tail.push_back('{op(svmie_pkg::OP_STP, 31, 31, 31, 1, 1, -64'sd1, -64'sd1, -64'sd1),
			1'b0, '0});
		tail.push_back('{op(svmie_pkg::OP_EXE, 0, 0, 0, 0, 0, MAXV, MINV, 0), 1'b0, '0});
		tail.push_back('{op(svmie_pkg::OP_ADDI, 1, 0, 0, 0, 0, 0, 5, 0), 1'b0, '0});
		tail.push_back('{op(svmie_pkg::OP_JAL, 3, 0, 0, 0, 0, 10, 10, 0), 1'b0, '0});
		tail.push_back('{op(svmie_pkg::OP_WU, 1, 0, 0, 0, 0, MAXV, 0, 0), 1'b0, '0});
		tail.push_back('{op(svmie_pkg::OP_BEQ, 0, 0, 0, 1, 1, 0, 7, 0), 1'b0, '0});
		tail.push_back('{op(svmie_pkg::OP_STP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (lead[i]) send(lead[i].ins, lead[i].typed, lead[i].want);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - CALM_ITEMS) calm = 1'b1;
			send(random_instr(), 1'b0, '0);
		end
		foreach (tail[i]) send(tail[i].ins, tail[i].typed, tail[i].want);
		instr_valid <= 1'b0;

		while (outstanding.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
